// ===== rtl/deadline_timer_bank_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the deadline timer bank
// Shorthands for clocked checks that are switched off while reset is low.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_BANK_UNIT_ASSERT_SVH
`define DEADLINE_TIMER_BANK_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define DTB_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define DTB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtb_pkg
// Types and constants shared by the deadline timer bank files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtb_pkg;

  // Command codes; the two top codes are unused and change nothing
  typedef enum logic [2:0] {
    CMD_START      = 3'd0,
    CMD_RESTART    = 3'd1,
    CMD_STOP       = 3'd2,
    CMD_FORCE_STOP = 3'd3,
    CMD_SET_PERIOD = 3'd4,
    CMD_SCAN       = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_EXPIRED = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } seq_state_t;

  localparam int PERIOD_W   = 46;
  localparam int TIME_W     = 63;
  localparam int MASK_W     = 16;
  localparam int MS_W       = 24;
  localparam int MHZ_W      = 12;
  localparam int PROD_W     = MS_W + MHZ_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [9:0]        KILO     = 10'd1000;
  localparam logic [MHZ_W-1:0]  MHZ_RESET = 12'd100;

  // One timer entry as held in the memory
  typedef struct packed {
    status_t               status;
    logic [PERIOD_W-1:0]   period;
    logic [TIME_W-1:0]     deadline;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{status: ST_STOPPED, period: '0, deadline: '0};

endpackage

// ===== rtl/dtb_ram.sv =====
// ----------------------------------------------------------------------------
// dtb_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/deadline_timer_bank_unit.sv =====
// A bank of NUM_TIMERS one-shot timers whose status, period and deadline sit
// in one memory (one write port, one registered read port). One item is
// worked at a time. A per-timer command reads its entry, modifies it and
// writes it back, and the next item is taken once the result is handed to
// the output register. A scan streams through the memory one entry per cycle
// with the write-back trailing the read by one entry; the single read port
// sets that pace. Results go through an output register, and reset needs no
// clearing pass: a valid bit per entry makes an unwritten entry read as
// stopped with a zero period.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// deadline_timer_bank_unit
// Command-driven one-shot timer bank with scan, expiry mask and earliest
// pending deadline.
// ----------------------------------------------------------------------------
module deadline_timer_bank_unit #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_clock_mhz,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_timer_index,
  input  logic [23:0] in_period_ms,
  input  logic [62:0] in_now,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_expired_mask,
  output logic [62:0] out_next_deadline,
  output logic [1:0]  out_timer_status
);

  import dtb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int ENT_W = $bits(entry_t);

  // Control state
  seq_state_t            state_r, state_nxt;
  logic [MHZ_W-1:0]      clk_mhz_r, clk_mhz_nxt;
  logic [NUM_TIMERS-1:0] valid_r, valid_nxt;
  logic [TIME_W-1:0]     earliest_r, earliest_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Item payload and working registers
  cmd_t                  cmd_r, cmd_nxt;
  logic                  idx_ok_r, idx_ok_nxt;
  logic [IDX_W-1:0]      idx_addr_r, idx_addr_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [PROD_W-1:0]     mul_r, mul_nxt;
  logic [IDX_W-1:0]      addr_r, addr_nxt;
  logic [MASK_W-1:0]     mask_r, mask_nxt;
  status_t               stat_r, stat_nxt;
  logic [MASK_W-1:0]     out_mask_r, out_mask_nxt;
  logic [TIME_W-1:0]     out_dl_r, out_dl_nxt;
  status_t               out_stat_r, out_stat_nxt;

  // Memory port signals
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  entry_t                ent_rd, ent_wr;

  // Helpers
  logic                  in_acc;
  logic [IDX_W+3:0]      in_idx_ext;
  logic [IDX_W+3:0]      addr_ext;
  logic [PERIOD_W-1:0]   period_new;
  logic [TIME_W:0]       arm_sum;
  logic [TIME_W-1:0]     arm_dl;

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign in_idx_ext = {{IDX_W{1'b0}}, in_timer_index};
  assign addr_ext   = {4'b0000, addr_r};

  // Entry as seen after the read; an entry never written reads as reset
  assign ent_rd = valid_r[addr_r] ? entry_t'(ram_rdata) : ENTRY_RESET;

  // Period in cycles: ms * MHz registered at accept, times 1000 here
  assign period_new = PERIOD_W'(PERIOD_W'(mul_r) * PERIOD_W'(KILO));

  // Deadline on arming, saturated at the largest time value
  assign arm_sum = {1'b0, now_r} + (TIME_W + 1)'(ent_rd.period);
  assign arm_dl  = arm_sum[TIME_W] ? TIME_MAX : arm_sum[TIME_W-1:0];

  dtb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ent_wr),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    clk_mhz_nxt   = clk_mhz_r;
    valid_nxt     = valid_r;
    earliest_nxt  = earliest_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_nxt       = cmd_r;
    idx_ok_nxt    = idx_ok_r;
    idx_addr_nxt  = idx_addr_r;
    now_nxt       = now_r;
    mul_nxt       = mul_r;
    addr_nxt      = addr_r;
    mask_nxt      = mask_r;
    stat_nxt      = stat_r;
    out_mask_nxt  = out_mask_r;
    out_dl_nxt    = out_dl_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = addr_r;
    ram_raddr     = in_idx_ext[IDX_W-1:0];
    ent_wr        = ent_rd;

    if (cfg_valid && cfg_ready) begin
      clk_mhz_nxt = cfg_clock_mhz;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = cmd_t'(in_command);
          idx_ok_nxt   = (32'(in_timer_index) < NUM_TIMERS);
          idx_addr_nxt = in_idx_ext[IDX_W-1:0];
          now_nxt      = in_now;
          mul_nxt      = PROD_W'(in_period_ms) * PROD_W'(clk_mhz_r);
          mask_nxt     = '0;
          stat_nxt     = ST_STOPPED;
          if (cmd_t'(in_command) == CMD_SCAN) begin
            earliest_nxt = TIME_MAX;
            cnt_nxt      = '0;
            pend_nxt     = 1'b0;
            state_nxt    = S_SCAN;
          end else begin
            ram_re    = 1'b1;
            addr_nxt  = in_idx_ext[IDX_W-1:0];
            state_nxt = S_EXEC;
          end
        end
      end

      // Per-timer command: modify the entry read last cycle and write back
      S_EXEC: begin
        if (idx_ok_r) begin
          case (cmd_r)
            CMD_START: begin
              if (ent_rd.status == ST_STOPPED) begin
                ent_wr.status   = ST_RUNNING;
                ent_wr.deadline = arm_dl;
                if (arm_dl < earliest_r) earliest_nxt = arm_dl;
              end
            end
            CMD_RESTART: begin
              if (ent_rd.status == ST_STOPPED || ent_rd.status == ST_EXPIRED) begin
                ent_wr.status   = ST_RUNNING;
                ent_wr.deadline = arm_dl;
                if (arm_dl < earliest_r) earliest_nxt = arm_dl;
              end
            end
            CMD_STOP: begin
              if (ent_rd.status == ST_RUNNING) ent_wr.status = ST_STOPPED;
            end
            CMD_FORCE_STOP: begin
              ent_wr.status = ST_STOPPED;
            end
            CMD_SET_PERIOD: begin
              ent_wr.period = period_new;
            end
            default: begin
            end
          endcase
          ram_we   = 1'b1;
          stat_nxt = ent_wr.status;
        end
        state_nxt = S_DONE;
      end

      // Scan: read entry cnt_r while the entry read last cycle is worked
      S_SCAN: begin
        if (32'(cnt_r) < NUM_TIMERS) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[IDX_W-1:0];
          addr_nxt  = cnt_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
        end
        if (pend_r) begin
          if (ent_rd.status == ST_RUNNING) begin
            if (ent_rd.deadline < now_r) begin
              ent_wr.status = ST_EXPIRED;
              ram_we        = 1'b1;
              if (32'(addr_r) < MASK_W) mask_nxt[addr_ext[3:0]] = 1'b1;
            end else if (ent_rd.deadline < earliest_r) begin
              earliest_nxt = ent_rd.deadline;
            end
          end
          if (idx_ok_r && (addr_r == idx_addr_r)) stat_nxt = ent_wr.status;
          if (cnt_r == CNT_W'(NUM_TIMERS)) state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = mask_r;
          out_dl_nxt    = earliest_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ram_we) valid_nxt[ram_waddr] = 1'b1;
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clk_mhz_r   <= MHZ_RESET;
      valid_r     <= '0;
      earliest_r  <= TIME_MAX;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clk_mhz_r   <= clk_mhz_nxt;
      valid_r     <= valid_nxt;
      earliest_r  <= earliest_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_ok_r   <= idx_ok_nxt;
    idx_addr_r <= idx_addr_nxt;
    now_r      <= now_nxt;
    mul_r      <= mul_nxt;
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    stat_r     <= stat_nxt;
    out_mask_r <= out_mask_nxt;
    out_dl_r   <= out_dl_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_expired_mask  = out_mask_r;
  assign out_next_deadline = out_dl_r;
  assign out_timer_status  = out_stat_r;

  // Checks
  `include "deadline_timer_bank_unit_assert.svh"

  `DTB_CHECK(a_no_write_idle, !(state_r == S_IDLE && ram_we), "memory written while idle")
  `DTB_CHECK(a_no_rw_overlap, !(ram_we && ram_re && ram_waddr == ram_raddr),
             "read and write hit the same entry")
  `DTB_CHECK(a_scan_pend, !(state_r == S_SCAN && cnt_r == CNT_W'(NUM_TIMERS)) || pend_r,
             "scan counter ran past pending read")
  `DTB_CHECK_NEXT(a_earliest_mono, !(in_acc && cmd_t'(in_command) == CMD_SCAN),
                  earliest_r <= $past(earliest_r), "earliest deadline rose outside scan")

endmodule

// ===== dv/deadline_timer_bank_unit_tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// deadline_timer_bank_unit_tb
// Self-checking bench for the timer bank. Commands go in over a valid/ready
// channel while a small scoreboard keeps its own copy of the bank (status,
// period, deadline, earliest deadline) and predicts every result item. The run
// starts with a directed pass over corner cases, then moves through several
// clock_mhz settings with random, mostly time-ordered command streams, random stalls
// on both sides, a long receiver hold-off and a calm stretch.
// ----------------------------------------------------------------------------
module deadline_timer_bank_unit_tb;
  import dtb_pkg::*;

  localparam int          TIMERS      = 16;
  localparam logic [2:0]  CMD_RSVD6   = 3'd6;
  localparam logic [2:0]  CMD_RSVD7   = 3'd7;
  localparam int          HOLD_CYCLES = 400;

  // expected result item
  typedef struct packed {
    logic [15:0]       mask;
    logic [TIME_W-1:0] next_dl;
    status_t           stat;
  } bank_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the bank plus a queue of expected results
  // --------------------------------------------------------------------------
  class timer_bank_scoreboard;
    status_t             bank_status [TIMERS];
    logic [PERIOD_W-1:0] bank_period [TIMERS];
    logic [TIME_W-1:0]   bank_deadline [TIMERS];
    logic [TIME_W-1:0]   earliest;
    logic [MHZ_W-1:0]    mhz;
    bank_result_t        expected_q[$];
    int                  errors;
    int                  compared;
    int                  expiring_scans;

    function new();
      for (int k = 0; k < TIMERS; k++) begin
        bank_status[k]   = ST_STOPPED;
        bank_period[k]   = '0;
        bank_deadline[k] = '0;
      end
      earliest       = TIME_MAX;
      mhz            = MHZ_RESET;
      errors         = 0;
      compared       = 0;
      expiring_scans = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function void set_clock(logic [MHZ_W-1:0] v);
      mhz = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // arm a timer: deadline = now + period, saturated
    function void arm(int k, logic [TIME_W-1:0] now);
      logic [TIME_W:0] sum;
      sum = {1'b0, now} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, bank_period[k]};
      if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
      bank_status[k]   = ST_RUNNING;
      bank_deadline[k] = sum[TIME_W-1:0];
      if (sum[TIME_W-1:0] < earliest) earliest = sum[TIME_W-1:0];
    endfunction

    // accepted input item: update shadow state, queue the expected result
    function void note_input(logic [2:0] cmd, logic [3:0] idx, logic [MS_W-1:0] ms,
                             logic [TIME_W-1:0] now);
      bank_result_t exp_item;
      logic [63:0]  prod;
      exp_item.mask = '0;
      case (cmd)
        CMD_SCAN: begin
          earliest = TIME_MAX;
          for (int k = 0; k < TIMERS; k++) begin
            if (bank_status[k] == ST_RUNNING) begin
              if (bank_deadline[k] < now) begin
                bank_status[k]   = ST_EXPIRED;
                exp_item.mask[k] = 1'b1;
              end else if (bank_deadline[k] < earliest) begin
                earliest = bank_deadline[k];
              end
            end
          end
          if (exp_item.mask != 0) expiring_scans++;
        end
        CMD_START:
          if (bank_status[idx] == ST_STOPPED) arm(idx, now);
        CMD_RESTART:
          if (bank_status[idx] != ST_RUNNING) arm(idx, now);
        CMD_STOP:
          if (bank_status[idx] == ST_RUNNING) bank_status[idx] = ST_STOPPED;
        CMD_FORCE_STOP:
          bank_status[idx] = ST_STOPPED;
        CMD_SET_PERIOD: begin
          prod = 64'(ms) * 64'(mhz) * 64'(KILO);
          bank_period[idx] = prod[PERIOD_W-1:0];
        end
        default: ;
      endcase
      exp_item.next_dl = earliest;
      exp_item.stat    = bank_status[idx];
      expected_q.push_back(exp_item);
    endfunction

    // accepted result item: compare field by field with the oldest expectation
    task check_result(logic [15:0] mask, logic [TIME_W-1:0] next_dl, logic [1:0] stat);
      bank_result_t exp_item;
      if (expected_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        exp_item = expected_q.pop_front();
        compared++;
        if (mask !== exp_item.mask)
          report_mismatch($sformatf("expired_mask %h, expected %h", mask, exp_item.mask));
        if (next_dl !== exp_item.next_dl)
          report_mismatch($sformatf("next_deadline %h, expected %h", next_dl,
                                    exp_item.next_dl));
        if (stat !== exp_item.stat)
          report_mismatch($sformatf("timer_status %0d, expected %0d", stat, exp_item.stat));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [11:0]       cfg_clock_mhz;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_command;
  logic [3:0]        in_timer_index;
  logic [23:0]       in_period_ms;
  logic [62:0]       in_now;
  logic              out_valid;
  logic              out_ready;
  logic [15:0]       out_expired_mask;
  logic [62:0]       out_next_deadline;
  logic [1:0]        out_timer_status;

  deadline_timer_bank_unit #(.NUM_TIMERS(TIMERS)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_clock_mhz     (cfg_clock_mhz),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_timer_index    (in_timer_index),
    .in_period_ms      (in_period_ms),
    .in_now            (in_now),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_expired_mask  (out_expired_mask),
    .out_next_deadline (out_next_deadline),
    .out_timer_status  (out_timer_status)
  );

  timer_bank_scoreboard sb;
  bit                   calm;            // no random idling on either side
  int                   rx_hold_request;
  int                   rx_hold_left;
  int                   items_sent;
  int                   settings_used;
  logic [TIME_W-1:0]    cur_time;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2ms;
    $display("timeout: bench stuck with %0d results outstanding", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check accepted items, random and forced back-pressure
  // --------------------------------------------------------------------------
  initial begin
    out_ready    <= 1'b0;
    rx_hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_expired_mask, out_next_deadline, out_timer_status);
      if (rx_hold_request > 0) begin
        rx_hold_left    = rx_hold_request;
        rx_hold_request = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic issue_command(logic [2:0] cmd, logic [3:0] idx, logic [MS_W-1:0] ms,
                               logic [TIME_W-1:0] now);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_timer_index <= idx;
    in_period_ms   <= ms;
    in_now         <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, idx, ms, now);
    items_sent++;
    // occasional gap before the next item
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_clock_mhz(logic [MHZ_W-1:0] v);
    wait_all_results();
    cfg_valid     <= 1'b1;
    cfg_clock_mhz <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_clock(v);
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  // random phase: time moves forward, deadlines land near the scan times
  task automatic run_phase(int count);
    int                sel;
    int                step;
    logic [2:0]        cmd;
    logic [3:0]        idx;
    logic [MS_W-1:0]   ms;
    logic [TIME_W-1:0] now;
    logic [63:0]       raw;
    step = (sb.mhz == 0) ? 1000 : int'(sb.mhz) * 1000;
    for (int i = 0; i < count; i++) begin
      idx = 4'($urandom_range(0, TIMERS - 1));
      sel = $urandom_range(0, 99);
      if (sel < 70)      ms = MS_W'($urandom_range(0, 4));
      else if (sel < 90) ms = MS_W'($urandom_range(0, 255));
      else               ms = MS_W'($urandom);
      cur_time = cur_time + TIME_W'($urandom_range(0, step));
      raw = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 85)      now = cur_time;
      else if (sel < 90) now = cur_time - TIME_W'($urandom_range(0, step));
      else if (sel < 95) now = raw[TIME_W-1:0];
      else               now = TIME_MAX - TIME_W'($urandom_range(0, 1000000));
      sel = $urandom_range(0, 99);
      if (sel < 25)      cmd = CMD_SCAN;
      else if (sel < 42) cmd = CMD_START;
      else if (sel < 58) cmd = CMD_RESTART;
      else if (sel < 66) cmd = CMD_STOP;
      else if (sel < 73) cmd = CMD_FORCE_STOP;
      else if (sel < 96) cmd = CMD_SET_PERIOD;
      else if (sel < 98) cmd = CMD_RSVD6;
      else               cmd = CMD_RSVD7;
      issue_command(cmd, idx, ms, now);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb              = new();
    calm            = 1'b0;
    rx_hold_request = 0;
    items_sent      = 0;
    settings_used   = 1;
    cur_time        = '0;
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_clock_mhz  <= '0;
    in_valid       <= 1'b0;
    in_command     <= '0;
    in_timer_index <= '0;
    in_period_ms   <= '0;
    in_now         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at the reset clock setting
    issue_command(CMD_SCAN, 4'd0, '0, '0);                     // empty bank
    issue_command(CMD_RSVD6, 4'd15, '1, TIME_MAX);             // unused codes
    issue_command(CMD_RSVD7, 4'd0, '1, TIME_MAX);
    issue_command(CMD_SET_PERIOD, 4'd0, '1, '0);               // largest period
    issue_command(CMD_SET_PERIOD, 4'd15, '0, '0);              // zero period
    issue_command(CMD_START, 4'd15, '0, TIME_MAX);             // deadline at max
    issue_command(CMD_START, 4'd0, '0, TIME_MAX);              // saturating sum
    issue_command(CMD_START, 4'd0, '0, '0);                    // already running
    issue_command(CMD_RESTART, 4'd0, '0, '0);
    issue_command(CMD_SET_PERIOD, 4'd1, 24'd1, '0);
    issue_command(CMD_RESTART, 4'd1, '0, 63'd1000);            // lowers earliest
    issue_command(CMD_SCAN, 4'd1, '0, 63'd101000);             // equal: not expired
    issue_command(CMD_SCAN, 4'd1, '0, 63'd101001);             // strictly later
    issue_command(CMD_STOP, 4'd1, '0, '0);                     // expired stays
    issue_command(CMD_START, 4'd1, '0, '0);                    // start ignores expired
    issue_command(CMD_RESTART, 4'd1, '0, '0);                  // restart from expired
    issue_command(CMD_STOP, 4'd1, '0, '0);
    issue_command(CMD_STOP, 4'd1, '0, '0);
    issue_command(CMD_FORCE_STOP, 4'd15, '0, '0);
    issue_command(CMD_FORCE_STOP, 4'd15, '0, '0);
    issue_command(CMD_SCAN, 4'd0, '0, TIME_MAX);
    issue_command(CMD_FORCE_STOP, 4'd0, '0, '0);
    issue_command(CMD_SCAN, 4'd7, '0, '0);

    // zero clock gives zero periods
    write_clock_mhz(12'd0);
    run_phase(60);

    // slowest clock; receiver holds off while commands keep coming
    write_clock_mhz(12'd1);
    rx_hold_request = HOLD_CYCLES;
    run_phase(260);

    // fastest clock, no idling on either side
    write_clock_mhz(12'hFFF);
    wait_all_results();
    calm = 1'b1;
    run_phase(250);
    calm = 1'b0;

    write_clock_mhz(MHZ_W'($urandom_range(2, 4094)));
    run_phase(250);

    write_clock_mhz(MHZ_RESET);
    run_phase(250);

    // drain and let any stray result surface
    wait_all_results();
    repeat (40) @(posedge clk);
    if (sb.pending() > 0) sb.report_mismatch("expected results never arrived");

    $display("ran %0d commands under %0d clock settings, compared %0d results",
             items_sent, settings_used, sb.compared);
    $display("%0d scans expired at least one timer", sb.expiring_scans);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dtb_pkg.sv
rtl/dtb_ram.sv
rtl/deadline_timer_bank_unit.sv
dv/deadline_timer_bank_unit_tb.sv
